@@ rtl/msp_pkg.sv @@
// ============================================================================
// msp_pkg: shared types and constants for the stepper position tracker
// Arm count, substep ratio, command codes, lane command/state structs and
// per-arm reset values.
// ============================================================================
package msp_pkg;

  localparam int DIAL_COUNT          = 4;
  localparam int ARM_COUNT           = DIAL_COUNT * 2;
  localparam int ARM_W               = $clog2(ARM_COUNT);
  localparam int SUBSTEPS_PER_DEGREE = 12;
  localparam int FULL_TURN           = 360;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_POS   = 2'd1;
  localparam logic [1:0] MODE_SPEED = 2'd2;

  localparam logic [3:0] SUBSTEP_WRAP = 4'(SUBSTEPS_PER_DEGREE);
  localparam logic [8:0] LAST_ANGLE   = 9'(FULL_TURN - 1);

  // Command for one arm lane, built from the registered input item.
  typedef struct packed {
    logic        tick;
    logic        target_wr;
    logic        recalc;
    logic        speed_wr;
    logic [15:0] target_val;
    logic [7:0]  speed_val;
    logic        dir_val;
  } lane_cmd_t;

  // Visible state of one arm after the current item.
  typedef struct packed {
    logic        pulse;
    logic        dir;
    logic [8:0]  angle;
    logic [15:0] remaining;
    logic        arrived;
    logic [7:0]  speed;
  } lane_out_t;

  function automatic logic [15:0] rst_target(logic [ARM_W-1:0] id);
    logic [15:0] v;
    v = 16'd0;
    if (id == ARM_W'(0)) v = 16'd90;
    if (id == ARM_W'(1)) v = 16'd180;
    return v;
  endfunction

  function automatic logic [15:0] rst_remaining(logic [ARM_W-1:0] id);
    logic [31:0] p;
    p = 32'(rst_target(id)) * 32'(SUBSTEPS_PER_DEGREE);
    return p[15:0];
  endfunction

  function automatic logic [7:0] rst_speed(logic [ARM_W-1:0] id);
    return (id == ARM_W'(1)) ? 8'd3 : 8'd2;
  endfunction

  function automatic logic rst_dir(logic [ARM_W-1:0] id);
    return (id == ARM_W'(0) || id == ARM_W'(1)) ? 1'b0 : 1'b1;
  endfunction

endpackage

@@ rtl/msp_arm_lane.sv @@
// ============================================================================
// msp_arm_lane: state and update logic of one stepper arm
// Holds angle, target, remaining steps, substep count, arrived flag, speed
// and direction; applies a step tick or a command.
// ============================================================================
module msp_arm_lane
  import msp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ARM_W-1:0] lane_id,
  input  lane_cmd_t        cmd,
  output lane_out_t        lane_nxt
);

  logic [8:0]  angle_r,     angle_nxt;
  logic [15:0] target_r,    target_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [3:0]  substep_r,   substep_nxt;
  logic        arrived_r,   arrived_nxt;
  logic [7:0]  speed_r,     speed_nxt;
  logic        dir_r,       dir_nxt;

  logic signed [17:0] diff;
  logic signed [17:0] diff_wrap;
  logic [31:0]        prod;
  logic [15:0]        rem_dec;
  logic [3:0]         sub_inc;
  logic               pulse;

  // Distance to target in degrees, wrapped by at most one turn.
  assign target_nxt = cmd.target_wr ? cmd.target_val : target_r;
  assign diff = $signed({2'b00, target_nxt}) - $signed({9'd0, angle_r});

  always_comb begin
    if (diff < 18'sd0) begin
      diff_wrap = diff + 18'(FULL_TURN);
    end else if (diff >= 18'(FULL_TURN)) begin
      diff_wrap = diff - 18'(FULL_TURN);
    end else begin
      diff_wrap = diff;
    end
  end

  assign prod    = 32'(diff_wrap[15:0]) * 32'(SUBSTEPS_PER_DEGREE);
  assign rem_dec = remaining_r - 16'd1;
  assign sub_inc = substep_r + 4'd1;
  assign pulse   = cmd.tick && (remaining_r != 16'd0);

  always_comb begin
    angle_nxt     = angle_r;
    remaining_nxt = remaining_r;
    substep_nxt   = substep_r;
    arrived_nxt   = arrived_r;
    if (cmd.recalc) begin
      remaining_nxt = prod[15:0];
    end else if (pulse) begin
      remaining_nxt = rem_dec;
      arrived_nxt   = (rem_dec == 16'd0);
      if (sub_inc == SUBSTEP_WRAP) begin
        substep_nxt = 4'd0;
        angle_nxt   = (angle_r >= LAST_ANGLE) ? 9'd0 : angle_r + 9'd1;
      end else begin
        substep_nxt = sub_inc;
      end
    end else if (cmd.tick) begin
      arrived_nxt = 1'b1;
    end
  end

  assign speed_nxt = cmd.speed_wr ? cmd.speed_val : speed_r;
  assign dir_nxt   = cmd.speed_wr ? cmd.dir_val   : dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r     <= 9'd0;
      target_r    <= rst_target(lane_id);
      remaining_r <= rst_remaining(lane_id);
      substep_r   <= 4'd0;
      arrived_r   <= 1'b1;
      speed_r     <= rst_speed(lane_id);
      dir_r       <= rst_dir(lane_id);
    end else begin
      angle_r     <= angle_nxt;
      target_r    <= target_nxt;
      remaining_r <= remaining_nxt;
      substep_r   <= substep_nxt;
      arrived_r   <= arrived_nxt;
      speed_r     <= speed_nxt;
      dir_r       <= dir_nxt;
    end
  end

  assign lane_nxt.pulse     = pulse;
  assign lane_nxt.dir       = dir_nxt;
  assign lane_nxt.angle     = angle_nxt;
  assign lane_nxt.remaining = remaining_nxt;
  assign lane_nxt.arrived   = arrived_nxt;
  assign lane_nxt.speed     = speed_nxt;

endmodule

@@ rtl/msp_out_reg.sv @@
// ============================================================================
// msp_out_reg: result register of the stepper position tracker
// Selects the addressed arm's updated state and holds it until it is taken.
// ============================================================================
module msp_out_reg
  import msp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic                        in_range,
  input  logic [ARM_W-1:0]            arm_idx,
  input  lane_out_t [ARM_COUNT-1:0]   lanes,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_step_pulse,
  output logic                        out_direction_level,
  output logic [8:0]                  out_arm_angle,
  output logic [15:0]                 out_steps_left,
  output logic                        out_in_position,
  output logic [7:0]                  out_speed_index
);

  logic      valid_r, valid_nxt;
  lane_out_t res_r, res_nxt;

  // An out-of-range dial reports an all-zero result.
  assign res_nxt = in_range ? lanes[arm_idx] : '0;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_step_pulse      = res_r.pulse;
  assign out_direction_level = res_r.dir;
  assign out_arm_angle       = res_r.angle;
  assign out_steps_left      = res_r.remaining;
  assign out_in_position     = res_r.arrived;
  assign out_speed_index     = res_r.speed;

endmodule

@@ rtl/multi_arm_stepper_position_tracker_top.sv @@
// ============================================================================
// multi_arm_stepper_position_tracker_top: step/direction tracker, eight arms
// Input register, eight arm lanes updated in one pass, result register.
// ============================================================================
// The block tracks eight stepper arms, a minute arm and an hour arm on each
// of four dials. A step tick for one arm issues a step pulse with that arm's
// direction while steps remain, counts the step down and advances the angle
// one degree every twelve substeps. A position command sets both target
// angles of one dial and recomputes the remaining steps of all eight arms at
// once; a speed and direction command stores one dial's speed indices and
// direction levels. Every accepted transaction returns exactly one result
// transaction describing the addressed arm after the item, or all zeros for
// a dial number of four or above. One transaction is accepted per clock
// cycle unless the input is stalled; an accepted item is held in the input
// register and then goes through the arm update logic into the result
// register, from which it is offered. The result register holds a finished
// transaction while the next input is already taken, so input stalls only
// when both registers are full.
// ============================================================================
module multi_arm_stepper_position_tracker_top
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_dial,
  input  logic        in_arm_select,
  input  logic [15:0] in_minute_value,
  input  logic [15:0] in_hour_value,
  input  logic        in_minute_direction,
  input  logic        in_hour_direction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_step_pulse,
  output logic        out_direction_level,
  output logic [8:0]  out_arm_angle,
  output logic [15:0] out_steps_left,
  output logic        out_in_position,
  output logic [7:0]  out_speed_index
);

  // Input register.
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_mode_r;
  logic [7:0]  s1_dial_r;
  logic        s1_sel_r;
  logic [15:0] s1_mval_r;
  logic [15:0] s1_hval_r;
  logic        s1_mdir_r;
  logic        s1_hdir_r;

  logic             advance;
  logic             fire;
  logic             in_range;
  logic [ARM_W-1:0] arm_idx;
  logic             do_tick;
  logic             do_pos;
  logic             do_speed;

  lane_cmd_t [ARM_COUNT-1:0] cmds;
  lane_out_t [ARM_COUNT-1:0] lanes;

  // The result register frees up when empty or when its transaction leaves.
  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r <= in_mode;
      s1_dial_r <= in_dial;
      s1_sel_r  <= in_arm_select;
      s1_mval_r <= in_minute_value;
      s1_hval_r <= in_hour_value;
      s1_mdir_r <= in_minute_direction;
      s1_hdir_r <= in_hour_direction;
    end
  end

  // Decode the registered item. Mode 3 and out-of-range dials touch no state.
  assign in_range = (s1_dial_r < 8'(DIAL_COUNT));
  assign arm_idx  = ARM_W'({s1_dial_r, s1_sel_r});
  assign do_tick  = fire && in_range && (s1_mode_r == MODE_TICK);
  assign do_pos   = fire && in_range && (s1_mode_r == MODE_POS);
  assign do_speed = fire && in_range && (s1_mode_r == MODE_SPEED);

  for (genvar k = 0; k < ARM_COUNT; k++) begin : g_lane
    // Even lanes are minute arms, odd lanes hour arms of dial k/2.
    logic dial_hit;
    assign dial_hit = (s1_dial_r == 8'(k / 2));

    assign cmds[k].tick       = do_tick && (arm_idx == ARM_W'(k));
    assign cmds[k].target_wr  = do_pos && dial_hit;
    assign cmds[k].recalc     = do_pos;
    assign cmds[k].speed_wr   = do_speed && dial_hit;
    assign cmds[k].target_val = ((k % 2) == 1) ? s1_hval_r : s1_mval_r;
    assign cmds[k].speed_val  = ((k % 2) == 1) ? s1_hval_r[7:0] : s1_mval_r[7:0];
    assign cmds[k].dir_val    = ((k % 2) == 1) ? s1_hdir_r : s1_mdir_r;

    msp_arm_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_id  (ARM_W'(k)),
      .cmd      (cmds[k]),
      .lane_nxt (lanes[k])
    );
  end

  msp_out_reg u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (fire),
    .in_range            (in_range),
    .arm_idx             (arm_idx),
    .lanes               (lanes),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_step_pulse      (out_step_pulse),
    .out_direction_level (out_direction_level),
    .out_arm_angle       (out_arm_angle),
    .out_steps_left      (out_steps_left),
    .out_in_position     (out_in_position),
    .out_speed_index     (out_speed_index)
  );

endmodule

@@ rtl/msp_checker.sv @@
// ============================================================================
// msp_checker: port-level assertions for the stepper position tracker
// Watches the top level's ports and is bound to the top level.
// ============================================================================
module msp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic [7:0]  in_dial,
  input logic        in_arm_select,
  input logic [15:0] in_minute_value,
  input logic [15:0] in_hour_value,
  input logic        in_minute_direction,
  input logic        in_hour_direction,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_step_pulse,
  input logic        out_direction_level,
  input logic [8:0]  out_arm_angle,
  input logic [15:0] out_steps_left,
  input logic        out_in_position,
  input logic [7:0]  out_speed_index
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_steps_left)
      && $stable(out_arm_angle) && $stable(out_step_pulse))
    else $error("result changed while stalled");

  // After a pulse the arrived flag mirrors an empty step count.
  a_arrive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_pulse |-> out_in_position == (out_steps_left == 16'd0))
    else $error("arrived flag disagrees with step count after a pulse");

  // The angle never leaves one turn.
  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_arm_angle < 9'd360)
    else $error("arm angle out of range");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind multi_arm_stepper_position_tracker_top msp_checker u_msp_checker (.*);
